// ===== hw/rtl/rsi_pkg.sv =====
// Shared types, constants and fixed-point helpers of the ray/sphere intersection unit
`default_nettype none
package rsi_pkg;

   localparam int WordBits = 32;
   localparam int FracBits = 16;
   localparam int RootBits = (WordBits + FracBits) / 2;
   localparam int DivBits  = WordBits + FracBits;

   typedef logic signed [WordBits-1:0] word_type;

   localparam word_type WordMax = {1'b0, {(WordBits-1){1'b1}}};
   localparam word_type WordMin = {1'b1, {(WordBits-1){1'b0}}};
   localparam word_type One     = word_type'(64'd1 << FracBits);

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CsrCenterX = 2'd0;
   localparam csr_index_type CsrCenterY = 2'd1;
   localparam csr_index_type CsrCenterZ = 2'd2;

   localparam logic ModeLoad = 1'b0;
   localparam logic ModeRay  = 1'b1;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } vec_type;

   typedef struct packed {
      vec_type td;
      vec_type s;
   } ray_type;

   typedef struct packed {
      logic     hit;
      logic     deg;
      word_type nb;
      word_type den;
      word_type disc;
   } quad_type;

   typedef struct packed {
      logic                hit;
      logic                deg;
      word_type            nb;
      word_type            den;
      logic [RootBits-1:0] root;
   } root_type;

   function automatic word_type vec_get(input vec_type v, input int k);
      word_type r;
      case (k)
         0:       r = v.x;
         1:       r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   function automatic word_type sadd(input word_type x, input word_type y);
      logic signed [WordBits:0] s;
      word_type r;
      s = {x[WordBits-1], x} + {y[WordBits-1], y};
      if (s[WordBits] != s[WordBits-1]) begin
         r = s[WordBits] ? WordMin : WordMax;
      end else begin
         r = s[WordBits-1:0];
      end
      return r;
   endfunction

   function automatic word_type sneg(input word_type x);
      word_type r;
      r = (x == WordMin) ? WordMax : -x;
      return r;
   endfunction

   function automatic word_type sum3(input word_type x, input word_type y,
                                     input word_type z);
      return sadd(sadd(x, y), z);
   endfunction

   // product truncated toward zero to the fraction, then saturated
   function automatic word_type fmul(input word_type x, input word_type y);
      logic signed [2*WordBits-1:0] p;
      logic signed [2*WordBits-1:0] t;
      word_type r;
      p = x * y;
      if (p < 0) begin
         p = p + $signed({{(2*WordBits-FracBits){1'b0}}, {FracBits{1'b1}}});
      end
      t = p >>> FracBits;
      if (t > WordMax) begin
         r = WordMax;
      end else if (t < WordMin) begin
         r = WordMin;
      end else begin
         r = t[WordBits-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rsi_xform.sv =====
// Matrix transform of origin and direction and centre subtraction, three stages
`default_nettype none
module rsi_xform (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   adv,
   input  wire logic                                   in_valid,
   input  wire rsi_pkg::vec_type                       origin,
   input  wire rsi_pkg::vec_type                       dir,
   input  wire logic [15:0][rsi_pkg::WordBits-1:0]     matrix,
   input  wire rsi_pkg::vec_type                       center,
   output logic                                        out_valid,
   output rsi_pkg::ray_type                            out_ray
);
   import rsi_pkg::*;

   word_type po_ff [3][3];
   word_type pd_ff [3][3];
   word_type tr_ff [3];
   logic     v1_ff, v2_ff, v3_ff;
   vec_type  to_ff, td_ff;
   ray_type  ray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               po_ff[r][k] <= fmul(word_type'(matrix[r*4+k]), vec_get(origin, k));
               pd_ff[r][k] <= fmul(word_type'(matrix[r*4+k]), vec_get(dir, k));
            end
            tr_ff[r] <= word_type'(matrix[r*4+3]);
         end
         to_ff.x <= sadd(sum3(po_ff[0][0], po_ff[0][1], po_ff[0][2]), tr_ff[0]);
         to_ff.y <= sadd(sum3(po_ff[1][0], po_ff[1][1], po_ff[1][2]), tr_ff[1]);
         to_ff.z <= sadd(sum3(po_ff[2][0], po_ff[2][1], po_ff[2][2]), tr_ff[2]);
         td_ff.x <= sum3(pd_ff[0][0], pd_ff[0][1], pd_ff[0][2]);
         td_ff.y <= sum3(pd_ff[1][0], pd_ff[1][1], pd_ff[1][2]);
         td_ff.z <= sum3(pd_ff[2][0], pd_ff[2][1], pd_ff[2][2]);
         ray_ff.td  <= td_ff;
         ray_ff.s.x <= sadd(to_ff.x, sneg(center.x));
         ray_ff.s.y <= sadd(to_ff.y, sneg(center.y));
         ray_ff.s.z <= sadd(to_ff.z, sneg(center.z));
      end
   end

   assign out_valid = v3_ff;
   assign out_ray   = ray_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rsi_quad.sv =====
// Quadratic coefficients and discriminant, four stages
`default_nettype none
module rsi_quad (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire rsi_pkg::ray_type  in_ray,
   output logic                   out_valid,
   output rsi_pkg::quad_type      out_quad
);
   import rsi_pkg::*;

   word_type tt_ff [3];
   word_type ts_ff [3];
   word_type ss_ff [3];
   word_type a_ff, b_ff, c_ff;
   word_type a2_ff, b2_ff, ac_ff, bb_ff;
   logic     v4_ff, v5_ff, v6_ff, v7_ff;
   quad_type quad_ff;
   word_type b1;
   word_type ac2;
   word_type ac4;
   word_type disc;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   assign b1   = sum3(ts_ff[0], ts_ff[1], ts_ff[2]);
   assign ac2  = sadd(ac_ff, ac_ff);
   assign ac4  = sadd(ac2, ac2);
   assign disc = sadd(bb_ff, sneg(ac4));

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            tt_ff[k] <= fmul(vec_get(in_ray.td, k), vec_get(in_ray.td, k));
            ts_ff[k] <= fmul(vec_get(in_ray.td, k), vec_get(in_ray.s, k));
            ss_ff[k] <= fmul(vec_get(in_ray.s, k), vec_get(in_ray.s, k));
         end
         a_ff  <= sum3(tt_ff[0], tt_ff[1], tt_ff[2]);
         b_ff  <= sadd(b1, b1);
         c_ff  <= sadd(sum3(ss_ff[0], ss_ff[1], ss_ff[2]), sneg(One));
         ac_ff <= fmul(a_ff, c_ff);
         bb_ff <= fmul(b_ff, b_ff);
         a2_ff <= a_ff;
         b2_ff <= b_ff;
         quad_ff.deg  <= (a2_ff == '0);
         quad_ff.hit  <= (a2_ff != '0) && (disc > 0);
         quad_ff.nb   <= sneg(b2_ff);
         quad_ff.den  <= sadd(a2_ff, a2_ff);
         quad_ff.disc <= disc;
      end
   end

   assign out_valid = v7_ff;
   assign out_quad  = quad_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rsi_sqrt.sv =====
// Pipelined floor square root of the scaled discriminant, one root bit per stage
`default_nettype none
module rsi_sqrt (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire rsi_pkg::quad_type  in_quad,
   output logic                    out_valid,
   output rsi_pkg::root_type       out_root
);
   import rsi_pkg::*;

   typedef struct packed {
      logic                hit;
      logic                deg;
      word_type            nb;
      word_type            den;
      logic [DivBits-1:0]  n;
      logic [RootBits+1:0] rem;
      logic [RootBits-1:0] root;
   } sq_type;

   sq_type stg_ff [RootBits];
   logic   v_ff   [RootBits];
   sq_type src    [RootBits];
   logic   vsrc   [RootBits];
   sq_type init;

   always_comb begin
      init      = '0;
      init.hit  = in_quad.hit;
      init.deg  = in_quad.deg;
      init.nb   = in_quad.nb;
      init.den  = in_quad.den;
      init.n    = {in_quad.disc, {FracBits{1'b0}}};
   end

   for (genvar i = 0; i < RootBits; i++) begin : g_step
      logic [RootBits+3:0] rem2;
      logic [RootBits+3:0] trial;
      logic [RootBits+3:0] diff;
      sq_type              nxt;

      if (i == 0) begin : g_first
         assign src[i]  = init;
         assign vsrc[i] = in_valid;
      end else begin : g_rest
         assign src[i]  = stg_ff[i-1];
         assign vsrc[i] = v_ff[i-1];
      end

      always_comb begin
         rem2  = {src[i].rem, src[i].n[DivBits-1 -: 2]};
         trial = {2'b00, src[i].root, 2'b01};
         diff  = rem2 - trial;
         nxt   = src[i];
         nxt.n = {src[i].n[DivBits-3:0], 2'b00};
         if (rem2 >= trial) begin
            nxt.rem  = diff[RootBits+1:0];
            nxt.root = {src[i].root[RootBits-2:0], 1'b1};
         end else begin
            nxt.rem  = rem2[RootBits+1:0];
            nxt.root = {src[i].root[RootBits-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= vsrc[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[i] <= nxt;
         end
      end
   end

   assign out_valid     = v_ff[RootBits-1];
   assign out_root.hit  = stg_ff[RootBits-1].hit;
   assign out_root.deg  = stg_ff[RootBits-1].deg;
   assign out_root.nb   = stg_ff[RootBits-1].nb;
   assign out_root.den  = stg_ff[RootBits-1].den;
   assign out_root.root = stg_ff[RootBits-1].root;

endmodule
`default_nettype wire

// ===== hw/rtl/rsi_div.sv =====
// Root numerators and two pipelined restoring dividers, one quotient bit per stage
`default_nettype none
module rsi_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire rsi_pkg::root_type  in_root,
   output logic                    out_valid,
   output logic                    out_hit,
   output logic                    out_deg,
   output rsi_pkg::word_type       out_near,
   output rsi_pkg::word_type       out_far
);
   import rsi_pkg::*;

   typedef struct packed {
      logic                neg;
      logic [DivBits-1:0]  n;
      logic [WordBits-1:0] rem;
      logic [DivBits-1:0]  q;
   } lane_type;

   typedef struct packed {
      logic     hit;
      logic     deg;
      word_type den;
      lane_type near;
      lane_type far;
   } dv_type;

   dv_type   head_ff;
   logic     head_v_ff;
   dv_type   stg_ff [DivBits];
   logic     v_ff   [DivBits];
   dv_type   src    [DivBits];
   logic     vsrc   [DivBits];
   word_type root_w;
   word_type num_near;
   word_type num_far;
   logic     hit_ff, deg_ff, out_v_ff;
   word_type near_ff, far_ff;

   function automatic lane_type lane_init(input word_type num);
      lane_type l;
      logic [WordBits-1:0] m;
      m      = num[WordBits-1] ? (~num + 1'b1) : num;
      l      = '0;
      l.neg  = num[WordBits-1];
      l.n    = {m, {FracBits{1'b0}}};
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l, input word_type den);
      lane_type o;
      logic [WordBits-1:0] rem2;
      rem2  = {l.rem[WordBits-2:0], l.n[DivBits-1]};
      o     = l;
      o.n   = {l.n[DivBits-2:0], 1'b0};
      if (rem2 >= den) begin
         o.rem = rem2 - den;
         o.q   = {l.q[DivBits-2:0], 1'b1};
      end else begin
         o.rem = rem2;
         o.q   = {l.q[DivBits-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic word_type lane_result(input lane_type l);
      word_type r;
      if (|l.q[DivBits-1:WordBits-1]) begin
         r = l.neg ? WordMin : WordMax;
      end else begin
         r = l.neg ? -word_type'(l.q[WordBits-1:0]) : word_type'(l.q[WordBits-1:0]);
      end
      return r;
   endfunction

   assign root_w   = word_type'({{(WordBits-RootBits){1'b0}}, in_root.root});
   assign num_near = sadd(in_root.nb, sneg(root_w));
   assign num_far  = sadd(in_root.nb, root_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         head_v_ff <= in_valid;
         out_v_ff  <= v_ff[DivBits-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         head_ff.hit  <= in_root.hit;
         head_ff.deg  <= in_root.deg;
         head_ff.den  <= in_root.den;
         head_ff.near <= lane_init(num_near);
         head_ff.far  <= lane_init(num_far);
      end
   end

   for (genvar i = 0; i < DivBits; i++) begin : g_step
      dv_type nxt;

      if (i == 0) begin : g_first
         assign src[i]  = head_ff;
         assign vsrc[i] = head_v_ff;
      end else begin : g_rest
         assign src[i]  = stg_ff[i-1];
         assign vsrc[i] = v_ff[i-1];
      end

      always_comb begin
         nxt      = src[i];
         nxt.near = lane_step(src[i].near, src[i].den);
         nxt.far  = lane_step(src[i].far, src[i].den);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= vsrc[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[i] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= stg_ff[DivBits-1].hit;
         deg_ff  <= stg_ff[DivBits-1].deg;
         near_ff <= stg_ff[DivBits-1].hit ? lane_result(stg_ff[DivBits-1].near) : '0;
         far_ff  <= stg_ff[DivBits-1].hit ? lane_result(stg_ff[DivBits-1].far) : '0;
      end
   end

   assign out_valid = out_v_ff;
   assign out_hit   = hit_ff;
   assign out_deg   = deg_ff;
   assign out_near  = near_ff;
   assign out_far   = far_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Top level: matrix store, centre registers and the intersection pipeline
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  req_    | in  | element_index, element_value, origin_x/y/z, dir_x/y/z | mode
//  rsp_    | out | t_near, t_far                                        | hit, degenerate
//  csr_    | in  | csr_we, csr_index, csr_wdata: center_x/y/z           | -
//
//  One word per cycle in while rsp_ is not stalled; a ray's result passes
//  through 3 transform, 4 coefficient, 24 root and 50 divider stages.
//  Load words write the matrix at acceptance and give no result.
//  Reset clears the valid bits, the centre and sets the matrix to identity.
//  A stalled result freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module ray_sphere_intersect (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [231:0]          req_tdata,  // element_index, element_value,
                                                  // origin_x, origin_y, origin_z,
                                                  // dir_x, dir_y, dir_z, zero pad
   input  wire logic                  req_tuser,  // mode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,  // t_near, t_far
   output logic [1:0]                 rsp_tuser,  // hit, degenerate
   input  wire logic                  csr_we,
   input  wire rsi_pkg::csr_index_type csr_index,
   input  wire logic [rsi_pkg::WordBits-1:0] csr_wdata
);
   import rsi_pkg::*;

   logic [15:0][WordBits-1:0] matrix_ff;
   vec_type   center_ff;
   logic      adv;
   logic      accept;
   logic      ray_valid;
   vec_type   origin;
   vec_type   dir;
   logic      xf_valid;
   ray_type   xf_ray;
   logic      qd_valid;
   quad_type  qd;
   logic      sq_valid;
   root_type  sq;
   logic      hit;
   logic      deg;
   word_type  t_near;
   word_type  t_far;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;
   assign ray_valid  = accept && (req_tuser == ModeRay);

   assign origin.x = req_tdata[67:36];
   assign origin.y = req_tdata[99:68];
   assign origin.z = req_tdata[131:100];
   assign dir.x    = req_tdata[163:132];
   assign dir.y    = req_tdata[195:164];
   assign dir.z    = req_tdata[227:196];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? One : '0;
         end
      end else if (accept && (req_tuser == ModeLoad)) begin
         matrix_ff[req_tdata[3:0]] <= req_tdata[35:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrCenterX: center_ff.x <= csr_wdata;
            CsrCenterY: center_ff.y <= csr_wdata;
            CsrCenterZ: center_ff.z <= csr_wdata;
            default: ;
         endcase
      end
   end

   rsi_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ray_valid),
      .origin    (origin),
      .dir       (dir),
      .matrix    (matrix_ff),
      .center    (center_ff),
      .out_valid (xf_valid),
      .out_ray   (xf_ray)
   );

   rsi_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (xf_valid),
      .in_ray    (xf_ray),
      .out_valid (qd_valid),
      .out_quad  (qd)
   );

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (qd_valid),
      .in_quad   (qd),
      .out_valid (sq_valid),
      .out_root  (sq)
   );

   rsi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_root   (sq),
      .out_valid (rsp_tvalid),
      .out_hit   (hit),
      .out_deg   (deg),
      .out_near  (t_near),
      .out_far   (t_far)
   );

   assign rsp_tdata = {t_far, t_near};
   assign rsp_tuser = {deg, hit};

endmodule
`default_nettype wire

// ===== hw/rtl/rsi_checker.sv =====
// Port-level checks of the intersection unit and their binding to the top level
`default_nettype none
module rsi_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("degenerate ray reported as hit");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("miss with non-zero roots");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         $signed(rsp_tdata[31:0]) <= $signed(rsp_tdata[63:32]))
      else $error("roots out of order");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
`default_nettype wire
